// ----- hdl/prx_pkg.sv -----
// ----------------------------------------------------------------------------
// prx_pkg: shared types and constants for the xyz point rotator
// widths, register codes, cordic arctangent table and datapath structs
// ----------------------------------------------------------------------------
`default_nettype none

package prx_pkg;

  localparam int COORD_W      = 32;
  localparam int ANGLE_W      = 16;
  localparam int COEF_W       = 18;
  localparam int COEF_FRAC    = 16;
  localparam int PROD_W       = COORD_W + COEF_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int MIX_W        = SUM_W - COEF_FRAC;
  localparam int NUM_AXES     = 3;
  localparam int AXIS_W       = 2;
  localparam int CORDIC_W     = 33;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = 3;
  localparam int FIFO_CW      = 4;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // register indexes (paddr[3:2])
  localparam logic [AXIS_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [AXIS_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [AXIS_W-1:0] REG_ANGLE_Z = 2'd2;

  localparam logic signed [COEF_W-1:0]   COEF_ONE    = 18'sd65536;
  localparam logic signed [COEF_W-1:0]   COEF_ZERO   = 18'sd0;
  localparam logic signed [SUM_W-1:0]    ROUND_HALF  = 51'sd32768;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [STEP_W-1:0]          LAST_STEP   = STEP_W'(CORDIC_STEPS - 1);

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // coefficient pair handed to one rotation cell
  typedef struct packed {
    logic                     load;
    logic signed [COEF_W-1:0] cos_q;
    logic signed [COEF_W-1:0] sin_q;
  } coef_load_t;

  // result of the shared trig unit
  typedef struct packed {
    logic                     valid;
    logic [AXIS_W-1:0]        axis;
    logic signed [COEF_W-1:0] cos_q;
    logic signed [COEF_W-1:0] sin_q;
  } trig_res_t;

  // word travelling along the chain of cells
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] p;
    logic                      flag;
  } cell_word_t;

  // rotated point waiting for the output
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      flag;
  } point_t;

endpackage

`default_nettype wire

// ----- hdl/prx_if.sv -----
// ----------------------------------------------------------------------------
// prx_if: valid/ready channels of the xyz point rotator
// input point channel and rotated point channel
// ----------------------------------------------------------------------------
`default_nettype none

interface prx_in_if import prx_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z,
                output ready);
endinterface

interface prx_out_if import prx_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rotated_x;
  logic signed [COORD_W-1:0] rotated_y;
  logic signed [COORD_W-1:0] rotated_z;
  logic                      saturated_flag;

  modport source (output valid, output rotated_x, output rotated_y,
                  output rotated_z, output saturated_flag, input ready);
  modport sink (input valid, input rotated_x, input rotated_y,
                input rotated_z, input saturated_flag, output ready);
endinterface

`default_nettype wire

// ----- hdl/point_rotate_xyz_core.sv -----
// ----------------------------------------------------------------------------
// point_rotate_xyz_core: euler xyz rotation of q16.16 points
// rotates each point about x, then y, then z by three programmable angles
// ----------------------------------------------------------------------------
//
//   channel   role     handshake                 word
//   -------   ------   -----------------------   ------------------------------
//   in_word   sink     valid/ready               coord_x, coord_y, coord_z
//   out_word  source   valid/ready               rotated_x/y/z, saturated_flag
//   apb       slave    psel/penable, pready=1    angle_about_x/y/z at 0x0/4/8
//
//   one word per cycle sustained unless an angle update or a full buffer holds off
//   the input; three rotation cells of two stages each, then the result buffer
//   writing an angle stalls the input while the single shared cordic unit works
//   on each axis written (24 iterations plus setup/round)
//   reset: synchronous, active low; angles 0, cosines one, sines zero
//   a stalled output fills the 8-word buffer; input is held off once
//   8 words are in flight, the chain itself never stops
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotate_xyz_core import prx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  prx_in_if.sink                 in_word,
  prx_out_if.source              out_word,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // configuration registers
  logic [NUM_AXES-1:0][ANGLE_W-1:0] angle_r;
  logic [AXIS_W-1:0]                reg_idx;
  logic                             wr_en;
  logic [NUM_AXES-1:0]              wr_axis;

  // shared trig unit and per-cell coefficient loads
  trig_res_t                        trig_res;
  logic                             trig_busy;
  coef_load_t                       coef_x, coef_y, coef_z;

  // chain of cells
  cell_word_t                       c0_in, c0_out, c1_in, c1_out, c2_in, c2_out;

  // output side
  point_t                           fifo_in, fifo_out;
  logic                             fifo_not_empty;
  logic                             in_fire, out_fire;
  logic [FIFO_CW-1:0]               inflight_r, inflight_nxt;

  // ---------------------------------------------------------------------------
  // apb register file, writes take effect on the access phase
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    wr_axis = '0;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ANGLE_X: wr_axis = 3'b001;
        REG_ANGLE_Y: wr_axis = 3'b010;
        REG_ANGLE_Z: wr_axis = 3'b100;
        default:     wr_axis = '0;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ANGLE_X: prdata = DATA_W'(angle_r[0]);
      REG_ANGLE_Y: prdata = DATA_W'(angle_r[1]);
      REG_ANGLE_Z: prdata = DATA_W'(angle_r[2]);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else begin
      if (wr_axis[0]) begin
        angle_r[0] <= pwdata[ANGLE_W-1:0];
      end
      if (wr_axis[1]) begin
        angle_r[1] <= pwdata[ANGLE_W-1:0];
      end
      if (wr_axis[2]) begin
        angle_r[2] <= pwdata[ANGLE_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // cos/sin generation, one axis at a time
  // ---------------------------------------------------------------------------
  prx_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_axis (wr_axis),
    .angle   (angle_r),
    .res_o   (trig_res),
    .busy_o  (trig_busy)
  );

  // the z rotation has the opposite sine sign, so its cell keeps -sin
  always_comb begin
    coef_x.load  = trig_res.valid && (trig_res.axis == REG_ANGLE_X);
    coef_x.cos_q = trig_res.cos_q;
    coef_x.sin_q = trig_res.sin_q;
    coef_y.load  = trig_res.valid && (trig_res.axis == REG_ANGLE_Y);
    coef_y.cos_q = trig_res.cos_q;
    coef_y.sin_q = trig_res.sin_q;
    coef_z.load  = trig_res.valid && (trig_res.axis == REG_ANGLE_Z);
    coef_z.cos_q = trig_res.cos_q;
    coef_z.sin_q = -trig_res.sin_q;
  end

  // ---------------------------------------------------------------------------
  // input acceptance: no angle update in progress and buffer credit left
  // ---------------------------------------------------------------------------
  assign in_word.ready = !trig_busy && (inflight_r < FIFO_CW'(FIFO_DEPTH));
  assign in_fire       = in_word.valid && in_word.ready;
  assign out_fire      = out_word.valid && out_word.ready;

  always_comb begin
    unique case ({in_fire, out_fire})
      2'b10:   inflight_nxt = inflight_r + FIFO_CW'(1);
      2'b01:   inflight_nxt = inflight_r - FIFO_CW'(1);
      default: inflight_nxt = inflight_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // rotation chain: x cell on (y,z), y cell on (x,z), z cell on (x,y)
  // ---------------------------------------------------------------------------
  always_comb begin
    c0_in.valid = in_fire;
    c0_in.a     = in_word.coord_y;
    c0_in.b     = in_word.coord_z;
    c0_in.p     = in_word.coord_x;
    c0_in.flag  = 1'b0;
  end

  prx_cell u_cell_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .coef_i (coef_x),
    .in_i   (c0_in),
    .out_o  (c0_out)
  );

  // after x: a = y', b = z', p = x
  always_comb begin
    c1_in.valid = c0_out.valid;
    c1_in.a     = c0_out.p;
    c1_in.b     = c0_out.b;
    c1_in.p     = c0_out.a;
    c1_in.flag  = c0_out.flag;
  end

  prx_cell u_cell_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .coef_i (coef_y),
    .in_i   (c1_in),
    .out_o  (c1_out)
  );

  // after y: a = x', b = z', p = y
  always_comb begin
    c2_in.valid = c1_out.valid;
    c2_in.a     = c1_out.a;
    c2_in.b     = c1_out.p;
    c2_in.p     = c1_out.b;
    c2_in.flag  = c1_out.flag;
  end

  prx_cell u_cell_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .coef_i (coef_z),
    .in_i   (c2_in),
    .out_o  (c2_out)
  );

  // after z: a = x', b = y', p = z
  always_comb begin
    fifo_in.x    = c2_out.a;
    fifo_in.y    = c2_out.b;
    fifo_in.z    = c2_out.p;
    fifo_in.flag = c2_out.flag;
  end

  // ---------------------------------------------------------------------------
  // result buffer decouples the output stall from the chain
  // ---------------------------------------------------------------------------
  prx_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (c2_out.valid),
    .wr_data   (fifo_in),
    .rd_en     (out_fire),
    .not_empty (fifo_not_empty),
    .rd_data   (fifo_out)
  );

  assign out_word.valid          = fifo_not_empty;
  assign out_word.rotated_x      = fifo_out.x;
  assign out_word.rotated_y      = fifo_out.y;
  assign out_word.rotated_z      = fifo_out.z;
  assign out_word.saturated_flag = fifo_out.flag;

endmodule

`default_nettype wire

// ----- hdl/prx_trig.sv -----
// ----------------------------------------------------------------------------
// prx_trig: shared cordic unit for the rotation angles
// folds the quadrant, iterates 24 cordic steps, rounds and clamps
// ----------------------------------------------------------------------------
`default_nettype none

module prx_trig import prx_pkg::*; (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [NUM_AXES-1:0]                wr_axis,
  input  wire logic [NUM_AXES-1:0][ANGLE_W-1:0]   angle,
  output trig_res_t                               res_o,
  output logic                                    busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ITER   = 3'b010,
    ST_FINISH = 3'b100
  } trig_state_t;

  trig_state_t                 state_r, state_nxt;
  logic [NUM_AXES-1:0]         pending_r, pending_nxt;
  logic [AXIS_W-1:0]           axis_r, axis_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [1:0]                  quad_r, quad_nxt;
  logic                        rzero_r, rzero_nxt;
  logic signed [CORDIC_W-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;

  logic [AXIS_W-1:0]           pick;
  logic [NUM_AXES-1:0]         clear;
  logic [ANGLE_W-1:0]          sel_angle;
  logic signed [CORDIC_W-1:0]  dx, dy, atn;
  logic signed [CORDIC_W:0]    xr, yr;
  logic signed [COEF_W-1:0]    c0, s0;

  // lowest pending axis first
  always_comb begin
    priority if (pending_r[0]) begin
      pick = REG_ANGLE_X;
    end else if (pending_r[1]) begin
      pick = REG_ANGLE_Y;
    end else begin
      pick = REG_ANGLE_Z;
    end
  end

  assign sel_angle = angle[pick];
  assign dx        = y_r >>> step_r;
  assign dy        = x_r >>> step_r;
  assign atn       = $signed({1'b0, atan_turn(step_r)});

  // round off the 14 extra bits and clamp to [0, one]
  assign xr = $signed({x_r[CORDIC_W-1], x_r} + (CORDIC_W+1)'(8192)) >>> 14;
  assign yr = $signed({y_r[CORDIC_W-1], y_r} + (CORDIC_W+1)'(8192)) >>> 14;

  always_comb begin
    if (rzero_r) begin
      c0 = COEF_ONE;
    end else if (xr < 0) begin
      c0 = COEF_ZERO;
    end else if (xr > (CORDIC_W+1)'(COEF_ONE)) begin
      c0 = COEF_ONE;
    end else begin
      c0 = xr[COEF_W-1:0];
    end
    if (rzero_r) begin
      s0 = COEF_ZERO;
    end else if (yr < 0) begin
      s0 = COEF_ZERO;
    end else if (yr > (CORDIC_W+1)'(COEF_ONE)) begin
      s0 = COEF_ONE;
    end else begin
      s0 = yr[COEF_W-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    step_nxt    = step_r;
    quad_nxt    = quad_r;
    rzero_nxt   = rzero_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    clear       = '0;
    res_o.valid = 1'b0;
    res_o.axis  = axis_r;
    res_o.cos_q = c0;
    res_o.sin_q = s0;

    // quadrant fold
    unique case (quad_r)
      2'd0: begin
        res_o.cos_q = c0;
        res_o.sin_q = s0;
      end
      2'd1: begin
        res_o.cos_q = -s0;
        res_o.sin_q = c0;
      end
      2'd2: begin
        res_o.cos_q = -c0;
        res_o.sin_q = -s0;
      end
      default: begin
        res_o.cos_q = s0;
        res_o.sin_q = -c0;
      end
    endcase

    unique case (state_r)
      ST_IDLE: begin
        if (|pending_r) begin
          clear       = NUM_AXES'(1) << pick;
          axis_nxt    = pick;
          step_nxt    = '0;
          quad_nxt    = sel_angle[ANGLE_W-1 -: 2];
          rzero_nxt   = (sel_angle[ANGLE_W-3:0] == '0);
          x_nxt       = CORDIC_GAIN;
          y_nxt       = '0;
          z_nxt       = $signed({3'b000, sel_angle[ANGLE_W-3:0], 16'h0000});
          state_nxt   = ST_ITER;
        end
      end
      ST_ITER: begin
        if (!z_r[CORDIC_W-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atn;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atn;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_o.valid = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a fresh write wins over the clear of the same axis
    pending_nxt = (pending_r & ~clear) | wr_axis;
  end

  assign busy_o = (state_r != ST_IDLE) || (|pending_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r  <= axis_nxt;
    step_r  <= step_nxt;
    quad_r  <= quad_nxt;
    rzero_r <= rzero_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/prx_cell.sv -----
// ----------------------------------------------------------------------------
// prx_cell: one plane rotation cell of the chain
// holds its cos/sin pair, a' = a*c + b*s, b' = b*c - a*s, rounded and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module prx_cell import prx_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire coef_load_t coef_i,
  input  wire cell_word_t in_i,
  output cell_word_t      out_o
);

  logic signed [COEF_W-1:0]  cos_r, sin_r;
  logic                      v1_r;
  logic signed [PROD_W-1:0]  ac_r, bs_r, as_r, bc_r;
  logic signed [PROD_W-1:0]  ac_nxt, bs_nxt, as_nxt, bc_nxt;
  logic signed [COORD_W-1:0] p1_r;
  logic                      f1_r;
  logic signed [SUM_W-1:0]   sum_a, sum_b;
  logic signed [MIX_W-1:0]   mix_a, mix_b;
  logic signed [COORD_W-1:0] sat_a, sat_b;
  logic                      clip_a, clip_b;
  cell_word_t                out_r, out_nxt;

  function automatic logic [COORD_W:0] saturate(input logic signed [MIX_W-1:0] v);
    logic [COORD_W:0] r;
    if (v[MIX_W-1:COORD_W-1] == '0 || v[MIX_W-1:COORD_W-1] == '1) begin
      r = {1'b0, v[COORD_W-1:0]};
    end else if (v[MIX_W-1]) begin
      r = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // stage 1: four exact products
  assign ac_nxt = PROD_W'(in_i.a) * PROD_W'(cos_r);
  assign bs_nxt = PROD_W'(in_i.b) * PROD_W'(sin_r);
  assign as_nxt = PROD_W'(in_i.a) * PROD_W'(sin_r);
  assign bc_nxt = PROD_W'(in_i.b) * PROD_W'(cos_r);

  // stage 2: sum, round half up, drop coefficient fraction, clip
  assign sum_a = SUM_W'(ac_r) + SUM_W'(bs_r) + ROUND_HALF;
  assign sum_b = SUM_W'(bc_r) - SUM_W'(as_r) + ROUND_HALF;
  assign mix_a = sum_a[SUM_W-1:COEF_FRAC];
  assign mix_b = sum_b[SUM_W-1:COEF_FRAC];
  assign {clip_a, sat_a} = saturate(mix_a);
  assign {clip_b, sat_b} = saturate(mix_b);

  always_comb begin
    out_nxt.valid = v1_r;
    out_nxt.a     = sat_a;
    out_nxt.b     = sat_b;
    out_nxt.p     = p1_r;
    out_nxt.flag  = f1_r | clip_a | clip_b;
  end

  assign out_o = out_r;

  // valid bits and coefficients are reset, the data path is not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r       <= COEF_ONE;
      sin_r       <= COEF_ZERO;
      v1_r        <= 1'b0;
      out_r.valid <= 1'b0;
    end else begin
      if (coef_i.load) begin
        cos_r <= coef_i.cos_q;
        sin_r <= coef_i.sin_q;
      end
      v1_r        <= in_i.valid;
      out_r.valid <= out_nxt.valid;
    end
    ac_r       <= ac_nxt;
    bs_r       <= bs_nxt;
    as_r       <= as_nxt;
    bc_r       <= bc_nxt;
    p1_r       <= in_i.p;
    f1_r       <= in_i.flag;
    out_r.a    <= out_nxt.a;
    out_r.b    <= out_nxt.b;
    out_r.p    <= out_nxt.p;
    out_r.flag <= out_nxt.flag;
  end

endmodule

`default_nettype wire

// ----- hdl/prx_ofifo.sv -----
// ----------------------------------------------------------------------------
// prx_ofifo: result buffer behind the chain of cells
// eight words, space guaranteed by the credit count at the input
// ----------------------------------------------------------------------------
`default_nettype none

module prx_ofifo import prx_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr_en,
  input  wire point_t wr_data,
  input  wire logic   rd_en,
  output logic        not_empty,
  output point_t      rd_data
);

  point_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + FIFO_CW'(1);
      2'b01:   count_nxt = count_r - FIFO_CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- tb/point_rotate_xyz_check.sv -----
// ----------------------------------------------------------------------------
// point_rotate_xyz_check: result checker for the xyz point rotator
// watches the point channels and the apb port, keeps its own angle
// coefficients, predicts every rotated word and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_rotate_xyz_check import prx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  prx_in_if                      in_mon,
  prx_out_if                     out_mon,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic              pready,
  output int                     fail_count,
  output int                     pending
);

  localparam int     TRIG_STEPS = 24;
  localparam longint TRIG_GAIN  = 64'sd652032874;
  localparam longint COORD_HI   = 64'sd2147483647;
  localparam longint COORD_LO   = -64'sd2147483648;

  // arctangent of 2^-i, in 2^-32 of a turn
  longint atan_step [TRIG_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic signed [COEF_W-1:0] cos_q [NUM_AXES];
  logic signed [COEF_W-1:0] sin_q [NUM_AXES];
  point_t                   rotated_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // quadrant fold, then cordic on the remainder within the quadrant
  function automatic void turn_to_trig(input  logic [ANGLE_W-1:0]     angle,
                                       output logic signed [COEF_W-1:0] cos_v,
                                       output logic signed [COEF_W-1:0] sin_v);
    longint cx, cy, cz, dx, dy, c0, s0;
    c0 = 64'sd65536;
    s0 = 64'sd0;
    if (angle[ANGLE_W-3:0] != '0) begin
      cx = TRIG_GAIN;
      cy = 0;
      cz = longint'(angle[ANGLE_W-3:0]) << (32 - ANGLE_W);
      for (int i = 0; i < TRIG_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cz >= 0) begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - atan_step[i];
        end else begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + atan_step[i];
        end
      end
      c0 = (cx + 8192) >>> 14;
      s0 = (cy + 8192) >>> 14;
      if (c0 < 0) c0 = 0;
      if (c0 > 65536) c0 = 65536;
      if (s0 < 0) s0 = 0;
      if (s0 > 65536) s0 = 65536;
    end
    case (angle[ANGLE_W-1:ANGLE_W-2])
      2'd0: begin
        cos_v = COEF_W'(c0);
        sin_v = COEF_W'(s0);
      end
      2'd1: begin
        cos_v = COEF_W'(-s0);
        sin_v = COEF_W'(c0);
      end
      2'd2: begin
        cos_v = COEF_W'(-c0);
        sin_v = COEF_W'(-s0);
      end
      default: begin
        cos_v = COEF_W'(s0);
        sin_v = COEF_W'(-c0);
      end
    endcase
  endfunction

  // two exact products, rounded half up on dropping the coefficient fraction
  function automatic longint blend(input longint a, input longint c,
                                   input longint b, input longint s);
    return (a * c + b * s + 64'sd32768) >>> COEF_FRAC;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic point_t rotate_point(input logic signed [COORD_W-1:0] px,
                                          input logic signed [COORD_W-1:0] py,
                                          input logic signed [COORD_W-1:0] pz);
    longint x, y, z, raw_a, raw_b, c, s;
    logic   hit;
    point_t res;
    x   = px;
    y   = py;
    z   = pz;
    hit = 1'b0;
    // about x
    c     = cos_q[REG_ANGLE_X];
    s     = sin_q[REG_ANGLE_X];
    raw_a = blend(y, c, z, s);
    raw_b = blend(y, -s, z, c);
    y     = clamp_coord(raw_a);
    z     = clamp_coord(raw_b);
    hit   = hit | (y != raw_a) | (z != raw_b);
    // about y
    c     = cos_q[REG_ANGLE_Y];
    s     = sin_q[REG_ANGLE_Y];
    raw_a = blend(x, c, z, s);
    raw_b = blend(x, -s, z, c);
    x     = clamp_coord(raw_a);
    z     = clamp_coord(raw_b);
    hit   = hit | (x != raw_a) | (z != raw_b);
    // about z
    c     = cos_q[REG_ANGLE_Z];
    s     = sin_q[REG_ANGLE_Z];
    raw_a = blend(x, c, y, -s);
    raw_b = blend(x, s, y, c);
    x     = clamp_coord(raw_a);
    y     = clamp_coord(raw_b);
    hit   = hit | (x != raw_a) | (y != raw_b);
    res.x    = x[COORD_W-1:0];
    res.y    = y[COORD_W-1:0];
    res.z    = z[COORD_W-1:0];
    res.flag = hit;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [COORD_W-1:0] want,
                                 input logic [COORD_W-1:0] got);
    $display("mismatch on %s at %0t ns: expected %h, got %h", what, $time, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    point_t            want;
    logic [AXIS_W-1:0] axis;
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        cos_q[k] = COEF_ONE;
        sin_q[k] = COEF_ZERO;
      end
      rotated_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (rotated_due.size() == 0) begin
          report_mismatch("word with none pending", '0, out_mon.rotated_x);
        end else begin
          want = rotated_due.pop_front();
          if (out_mon.rotated_x !== want.x)
            report_mismatch("rotated_x", want.x, out_mon.rotated_x);
          if (out_mon.rotated_y !== want.y)
            report_mismatch("rotated_y", want.y, out_mon.rotated_y);
          if (out_mon.rotated_z !== want.z)
            report_mismatch("rotated_z", want.z, out_mon.rotated_z);
          if (out_mon.saturated_flag !== want.flag)
            report_mismatch("saturated_flag", COORD_W'(want.flag),
                            COORD_W'(out_mon.saturated_flag));
        end
      end
      if (in_mon.valid && in_mon.ready)
        rotated_due.push_back(rotate_point(in_mon.coord_x, in_mon.coord_y, in_mon.coord_z));
      if (psel && penable && pwrite && pready) begin
        axis = paddr[3:2];
        if (axis == REG_ANGLE_X || axis == REG_ANGLE_Y || axis == REG_ANGLE_Z)
          turn_to_trig(pwdata[ANGLE_W-1:0], cos_q[axis], sin_q[axis]);
      end
    end
    pending <= rotated_due.size();
  end

endmodule

// ----- tb/point_rotate_xyz_core_test.sv -----
// ----------------------------------------------------------------------------
// point_rotate_xyz_core_test: top level bench for the xyz point rotator
// directed points at extreme angles and coordinates, then random points over
// several angle settings with sender gaps, receiver stalls and a long hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_rotate_xyz_core_test;
  import prx_pkg::*;

  localparam int RUN_LIMIT    = 100000;  // cycles, far beyond the slowest run
  localparam int DRAIN_CYCLES = 20;      // quiet time after the last word
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int PHASE_POINTS = 230;
  localparam int NUM_PHASES   = 8;

  // address slot past the three angle registers, writes there are dropped
  localparam logic [AXIS_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
  localparam logic signed [COORD_W-1:0] COORD_ONE = 32'sh00010000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   fail_count;
  int   pending;
  int   cycle_count;
  int   hold_count;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;

  prx_in_if  in_word ();
  prx_out_if out_word ();

  point_rotate_xyz_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  point_rotate_xyz_check rotate_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_word),
    .out_mon    (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off once it is requested
  initial begin
    out_word.ready = 1'b0;
    hold_count     = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_count < HOLD_CYCLES) begin
        out_word.ready <= 1'b0;
        hold_count++;
      end else begin
        out_word.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // offer one point, with random idle cycles ahead of it, and wait for the handshake
  task automatic send_point(input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py,
                            input logic signed [COORD_W-1:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid   <= 1'b1;
    in_word.coord_x <= px;
    in_word.coord_y <= py;
    in_word.coord_z <= pz;
    do @(posedge clk); while (!in_word.ready);
  endtask

  // setup, then access, then psel dropped before returning, so writes never overlap
  task automatic write_angle(input logic [AXIS_W-1:0] axis, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {axis, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait until every predicted word has come out
  task automatic wait_drained();
    in_word.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly full-range noise or scaled-down values, some exact extremes
  function automatic logic signed [COORD_W-1:0] pick_coord();
    logic [COORD_W-1:0] raw;
    int unsigned        sel;
    raw = $urandom;
    sel = $urandom_range(9);
    if (sel < 4) return raw;
    if (sel < 8) return $signed(raw) >>> $urandom_range(30, 8);
    case ($urandom_range(4))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // angle with junk in the upper bits, which the block must mask off
  function automatic logic [DATA_W-1:0] pick_angle();
    logic [DATA_W-1:0] noise;
    noise = $urandom;
    case ($urandom_range(5))
      0:       return {noise[31:16], 16'h0000};
      1:       return {noise[31:16], 16'hFFFF};
      2:       return {noise[31:16], noise[15:14], 14'h0000};
      3:       return {noise[31:16], noise[15:14], 14'h0001};
      default: return noise;
    endcase
  endfunction

  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_word.valid    = 1'b0;
    in_word.coord_x  = '0;
    in_word.coord_y  = '0;
    in_word.coord_z  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset angles: every stage passes the point straight through
    send_point('0, '0, '0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(32'sd1, -32'sd1, COORD_ONE);
    wait_drained();

    // write to the unused slot is ignored, still identity
    write_angle(REG_UNUSED, 32'h0000_4000);
    send_point(COORD_MAX, '0, COORD_MIN);
    wait_drained();

    // quarter turns give exact coefficients; negating the minimum clips
    write_angle(REG_ANGLE_X, 32'h0000_4000);
    write_angle(REG_ANGLE_Y, 32'h0000_8000);
    write_angle(REG_ANGLE_Z, 32'h0000_C000);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(COORD_ONE, 32'sh00020000, -32'sh00030000);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    wait_drained();

    // eighth turns on x and y, just under a full turn on z, upper data bits set; big points clip mid-chain
    write_angle(REG_ANGLE_X, 32'hABCD_2000);
    write_angle(REG_ANGLE_Y, 32'hFFFF_2000);
    write_angle(REG_ANGLE_Z, 32'h0001_FFFF);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(32'sd1, 32'sd1, 32'sd1);
    send_point(-32'sd1, '0, 32'sd1);
    send_point('0, COORD_MAX, COORD_MIN);
    wait_drained();

    // smallest and largest angle steps
    write_angle(REG_ANGLE_X, 32'h0000_0001);
    write_angle(REG_ANGLE_Y, 32'h0000_FFFF);
    write_angle(REG_ANGLE_Z, 32'h0000_6000);
    send_point(COORD_MAX, COORD_MIN, COORD_ONE);
    send_point(32'sh00008000, -32'sh00008000, 32'sh7FFF0000);
    send_point(-32'sd1, -32'sd1, -32'sd1);
    wait_drained();

    // one angle in each of the quadrants past the first
    write_angle(REG_ANGLE_X, 32'h0000_9C40);
    write_angle(REG_ANGLE_Y, 32'h0000_EA60);
    write_angle(REG_ANGLE_Z, 32'h0000_4E20);
    send_point(COORD_ONE, 32'sh12345678, -32'sh0ABCDEF0);
    send_point(COORD_MIN, COORD_MAX, '0);
    send_point(32'sh40000000, 32'sh40000000, 32'sh40000000);
    wait_drained();

    // random phases, by p mod 4: 0 no idling, 1 sender gaps, 2 receiver stalls, 3 both
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        write_angle(REG_ANGLE_X, 32'hFFFF_FFFF);
        write_angle(REG_ANGLE_Y, 32'h0000_FFFF);
        write_angle(REG_ANGLE_Z, 32'h1234_FFFF);
      end else begin
        write_angle(REG_ANGLE_X, pick_angle());
        write_angle(REG_ANGLE_Y, pick_angle());
        write_angle(REG_ANGLE_Z, pick_angle());
      end
      if (p % 3 == 1)
        write_angle(REG_UNUSED, $urandom);
      send_idle_pct  <= (p % 4 == 1) ? 47 : (p % 4 == 3) ? 25 : 0;
      recv_stall_pct <= (p % 4 == 2) ? 47 : (p % 4 == 3) ? 25 : 0;
      // long hold-off while points keep coming: buffer fills, input backs up
      if (p == 4)
        hold_req <= 1'b1;
      for (int n = 0; n < PHASE_POINTS; n++)
        send_point(pick_coord(), pick_coord(), pick_coord());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
